### rtl/mmt_pkg.sv
// package for the midi message transmit queue: item types, opcodes, sizes
// no dependencies; imported by mmt_queue and midi_message_tx_fifo_top
`timescale 1ns / 1ps

package mmt_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int FILL_W    = 6;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ONE   = 2'd1,
		OP_TWO   = 2'd2,
		OP_THREE = 2'd3
	} op_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] status_byte;
		logic [7:0] data_first;
		logic [7:0] data_second;
	} in_item_t;

	typedef struct packed {
		logic              rejected;
		logic              tx_valid;
		logic [7:0]        tx_byte;
		logic [FILL_W-1:0] fill_level;
	} out_item_t;

endpackage

### rtl/midi_message_tx_fifo_top.sv
// top level of the midi message transmit queue
// depends on mmt_pkg and mmt_queue
//
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// input    | start (busy always 0) | msg: opcode, status_byte, data_first,
//          |                       |      data_second
// result   | result_valid strobe   | result: rejected, tx_valid, tx_byte,
//          |                       |         fill_level
// config   | cfg_we                | cfg_wdata -> tx_enable (reset 1)
//
// one item per cycle, every cycle; busy never rises
// the path is the input register, then the result register after the
// queue update, which is one wrap add, a compare and a byte-store mux
// arst_n clears the valid flags, read pointer and count; the byte store
// is not cleared, so no clearing pass is needed
// the receiver cannot stall: each result shows for exactly one cycle
`timescale 1ns / 1ps

module midi_message_tx_fifo_top import mmt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  msg,
	output logic      result_valid,
	output out_item_t result,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	logic      tx_enable_q;
	out_item_t step_res;

	// the queue answers every cycle, so nothing ever holds the input off
	assign busy = 1'b0;

	// transmitter enable, written only while no item is in flight (user's rule; the block does not enforce it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_enable_q <= 1'b1;
		end else if (cfg_we) begin
			tx_enable_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= msg;
		end
	end

	// queue state advances at the same edge the result is captured
	mmt_queue #(
		.DEPTH(DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item      (item_s1),
		.tx_enable (tx_enable_q),
		.res       (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= step_res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

### rtl/mmt_queue.sv
// byte ring buffer with pointer/count state and the per-item decision logic
// depends on mmt_pkg
`timescale 1ns / 1ps

module mmt_queue import mmt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  in_item_t  item,
	input  logic      tx_enable,
	output out_item_t res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL   = CW'(DEPTH);
	localparam logic [CW-1:0] ROOM3  = CW'(DEPTH - 2);
	localparam logic [AW:0]   DEPTHX = (AW+1)'(DEPTH);

	logic [7:0]    store_q [DEPTH];
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	logic [AW:0]   base_sum;
	logic [AW-1:0] wr0, wr1, wr2, rd_next;
	logic          do_pop, push1, push2, push3, rejected;
	logic [CW-1:0] count_next;

	// tail slot: rd + count stays below twice the depth, one subtract wraps it
	always_comb begin
		base_sum = {1'b0, rd_q} + (AW+1)'(count_q);
		if (base_sum >= DEPTHX) begin
			base_sum = base_sum - DEPTHX;
		end
		wr0     = base_sum[AW-1:0];
		wr1     = (wr0 == LAST) ? '0 : wr0 + 1'b1;
		wr2     = (wr1 == LAST) ? '0 : wr1 + 1'b1;
		rd_next = (rd_q == LAST) ? '0 : rd_q + 1'b1;
	end

	always_comb begin
		do_pop   = 1'b0;
		push1    = 1'b0;
		push2    = 1'b0;
		push3    = 1'b0;
		rejected = 1'b0;
		case (item.opcode)
			OP_TICK: begin
				do_pop = (count_q != '0) && tx_enable;
			end
			OP_ONE: begin
				push1    = (count_q < FULL);
				rejected = !push1;
			end
			OP_TWO: begin
				push1    = (count_q < ROOM3);
				push2    = push1;
				rejected = !push1;
			end
			OP_THREE: begin
				push1    = (count_q < ROOM3);
				push2    = push1;
				push3    = push1;
				rejected = !push1;
			end
			default: begin
				rejected = 1'b0;
			end
		endcase
		count_next = count_q + CW'(push1) + CW'(push2) + CW'(push3) - CW'(do_pop);

		res.rejected   = rejected;
		res.tx_valid   = do_pop;
		res.tx_byte    = do_pop ? store_q[rd_q] : 8'h00;
		res.fill_level = FILL_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			count_q <= '0;
		end else if (item_valid) begin
			count_q <= count_next;
			if (do_pop) begin
				rd_q <= rd_next;
			end
		end
	end

	// storage holds no reset; only queued slots are ever read
	always_ff @(posedge clk) begin
		if (item_valid) begin
			if (push1) begin
				store_q[wr0] <= item.status_byte;
			end
			if (push2) begin
				store_q[wr1] <= item.data_first;
			end
			if (push3) begin
				store_q[wr2] <= item.data_second;
			end
		end
	end

endmodule
